// File: rtl/stdc_pkg.sv
// Shared types, constants and helpers for the session token derive and check unit.
package stdc_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] DEFAULT_CODE = 32'h4252_5448;
    localparam logic [WORD_W-1:0] SEED_A       = 32'hA5C2_E1F7;
    localparam logic [WORD_W-1:0] SEED_B       = 32'h7F1E_3C5A;
    localparam logic [WORD_W-1:0] SEED_SUM     = SEED_A + SEED_B;

    localparam logic [WORD_W-1:0] MIX_MUL_1    = 32'h5BD1_E995;
    localparam logic [WORD_W-1:0] MIX_MUL_2    = 32'h27D4_EB2F;
    localparam logic [WORD_W-1:0] MIX_KEY_XOR  = 32'h6C07_8965;
    localparam logic [WORD_W-1:0] FNV_MUL      = 32'h0100_0193;

    localparam logic REQ_STAMP    = 1'b0;
    localparam logic REQ_VALIDATE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] presented_a;
        logic [WORD_W-1:0] presented_b;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] token_a;
        logic [WORD_W-1:0] token_b;
        logic              tokens_match;
    } result_t;

    typedef struct packed {
        logic              busy;
        logic [WORD_W-1:0] token_a;
        logic [WORD_W-1:0] token_b;
    } hash_status_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

// File: rtl/stdc_token_hash.sv
// Multi-cycle token derivation engine sharing one 32x32 multiplier.
module stdc_token_hash (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [stdc_pkg::WORD_W-1:0] code,
    output stdc_pkg::hash_status_t      status
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_START = 7'b000_0010,
        ST_HALF1 = 7'b000_0100,
        ST_HALF2 = 7'b000_1000,
        ST_FIN   = 7'b001_0000,
        ST_FNV   = 7'b010_0000,
        ST_ADJ   = 7'b100_0000
    } state_t;

    // Which mix3 call of the derivation is running
    localparam logic [2:0] CALL_SEED_A = 3'd0;
    localparam logic [2:0] CALL_SEED_B = 3'd1;
    localparam logic [2:0] CALL_CODE   = 3'd2;
    localparam logic [2:0] CALL_CROSS  = 3'd3;
    localparam logic [2:0] CALL_FINAL  = 3'd4;

    localparam logic [1:0] LAST_ROUND = 2'd2;

    state_t     state_reg, state_next;
    logic [1:0] round_reg, round_next;
    logic [2:0] call_reg,  call_next;

    logic [stdc_pkg::WORD_W-1:0] x_reg,  x_next;
    logic [stdc_pkg::WORD_W-1:0] k_reg,  k_next;
    logic [stdc_pkg::WORD_W-1:0] p_reg,  p_next;
    logic [stdc_pkg::WORD_W-1:0] wa_reg, wa_next;
    logic [stdc_pkg::WORD_W-1:0] wb_reg, wb_next;
    logic [stdc_pkg::WORD_W-1:0] tok_a_reg, tok_a_next;
    logic [stdc_pkg::WORD_W-1:0] tok_b_reg, tok_b_next;

    logic [stdc_pkg::WORD_W-1:0] round_key;
    logic [stdc_pkg::WORD_W-1:0] mul_op;
    logic [stdc_pkg::WORD_W-1:0] mul_k;
    logic [stdc_pkg::WORD_W-1:0] prod;

    always_comb
    begin
        case (round_reg)
            2'd0:    round_key = k_reg;
            2'd1:    round_key = k_reg ^ stdc_pkg::MIX_KEY_XOR;
            default: round_key = stdc_pkg::rotl32(k_reg, 17);
        endcase
    end

    // One shared multiplier, operands steered by state
    always_comb
    begin
        case (state_reg)
            ST_HALF1:
            begin
                mul_op = stdc_pkg::rotl32(x_reg ^ round_key, 13);
                mul_k  = stdc_pkg::MIX_MUL_1;
            end
            ST_HALF2:
            begin
                mul_op = p_reg ^ (p_reg >> 15);
                mul_k  = stdc_pkg::MIX_MUL_2;
            end
            default:
            begin
                mul_op = wa_reg;
                mul_k  = stdc_pkg::FNV_MUL;
            end
        endcase
    end

    assign prod = mul_op * mul_k;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        call_next  = call_reg;
        x_next     = x_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        wa_next    = wa_reg;
        wb_next    = wb_reg;
        tok_a_next = tok_a_reg;
        tok_b_next = tok_b_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                x_next     = code;
                k_next     = stdc_pkg::SEED_A;
                call_next  = CALL_SEED_A;
                round_next = 2'd0;
                state_next = ST_HALF1;
            end
            ST_HALF1:
            begin
                p_next     = prod;
                state_next = ST_HALF2;
            end
            ST_HALF2:
            begin
                x_next = prod ^ (prod >> 13);
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    round_next = round_reg + 2'd1;
                    state_next = ST_HALF1;
                end
            end
            ST_FIN:
            begin
                round_next = 2'd0;
                state_next = ST_HALF1;
                case (call_reg)
                    CALL_SEED_A:
                    begin
                        wa_next   = x_reg;
                        x_next    = code;
                        k_next    = stdc_pkg::SEED_B;
                        call_next = CALL_SEED_B;
                    end
                    CALL_SEED_B:
                    begin
                        wb_next   = x_reg;
                        wa_next   = wa_reg ^ stdc_pkg::rotl32(x_reg, 16);
                        x_next    = wa_next;
                        k_next    = code;
                        call_next = CALL_CODE;
                    end
                    CALL_CODE:
                    begin
                        wb_next   = wb_reg + x_reg;
                        x_next    = wa_reg;
                        k_next    = wb_next;
                        call_next = CALL_CROSS;
                    end
                    CALL_CROSS:
                    begin
                        wa_next    = x_reg;
                        state_next = ST_FNV;
                    end
                    default:
                    begin
                        tok_a_next = wa_reg;
                        tok_b_next = wb_reg ^ x_reg;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FNV:
            begin
                wb_next    = wb_reg ^ prod;
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                wa_next    = wa_reg + (stdc_pkg::rotl32(code, 5) ^
                                       stdc_pkg::rotl32(wb_reg, 23));
                x_next     = wa_next ^ code;
                k_next     = stdc_pkg::SEED_SUM;
                call_next  = CALL_FINAL;
                round_next = 2'd0;
                state_next = ST_HALF1;
            end
            default:
            begin
                state_next = ST_START;
            end
        endcase
    end

    // Reset lands in START so the default code is hashed straight away
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            round_reg <= 2'd0;
            call_reg  <= CALL_SEED_A;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            call_reg  <= call_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        k_reg     <= k_next;
        p_reg     <= p_next;
        wa_reg    <= wa_next;
        wb_reg    <= wb_next;
        tok_a_reg <= tok_a_next;
        tok_b_reg <= tok_b_next;
    end

    assign status.busy    = (state_reg != ST_IDLE);
    assign status.token_a = tok_a_reg;
    assign status.token_b = tok_b_reg;

endmodule

// File: rtl/session_token_derive_check_unit.sv
// Top level of the session token derive and check unit.
//
// Channels:
//   cfg_valid/cfg_ready/cfg_data - write beat for the required code. A beat
//     of zero is taken and dropped. A nonzero beat loads the code and starts
//     a fresh derivation of the token pair.
//   start/busy/item - one request beat is taken at each edge where start is
//     high and busy is low. req_type selects stamp or validate.
//   done/result - each result beat shows for exactly one cycle, flagged by
//     done. The receiver cannot stall, so nothing is ever held back here.
// Pipeline: a request passes the input, compare and output registers in turn
//   before its result shows, and one request can be taken every cycle while
//   busy is low.
// Derivation: the token pair is worked out by a sequencer around one shared
//   32x32 multiplier, each mixing round running the HALF1 and HALF2 states in turn.
//   Busy and a low cfg_ready cover the whole derivation.
// Reset: the code returns to its default value and the derivation runs
//   at once, so busy stays high after reset is released until it finishes.
module session_token_derive_check_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [stdc_pkg::WORD_W-1:0] cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  stdc_pkg::item_t             item,
    output logic                        done,
    output stdc_pkg::result_t           result
);

    logic [stdc_pkg::WORD_W-1:0] code_reg, code_next;
    logic                        cfg_beat;
    logic                        load;
    stdc_pkg::hash_status_t      hash_status;

    // Stage 1: captured request
    logic                        s1_valid_reg;
    stdc_pkg::item_t             s1_item_reg;
    // Stage 2: per-word compare
    logic                        s2_valid_reg;
    logic                        s2_req_reg;
    logic                        s2_eq_a_reg;
    logic                        s2_eq_b_reg;
    // Stage 3: output beat
    logic                        s3_valid_reg;
    stdc_pkg::result_t           s3_result_reg;

    // Configuration: take beats only while the token pair is settled
    assign cfg_ready = !hash_status.busy;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign load      = cfg_beat && (cfg_data != '0);
    assign code_next = load ? cfg_data : code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= stdc_pkg::DEFAULT_CODE;
        end
        else
        begin
            code_reg <= code_next;
        end
    end

    stdc_token_hash u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .code   (code_reg),
        .status (hash_status)
    );

    assign busy = hash_status.busy;

    // Valid bits advance every cycle; the receiver never pushes back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !hash_status.busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload carries no reset; the valid bits qualify it
    always_ff @(posedge clk)
    begin
        s1_item_reg <= item;

        s2_req_reg  <= s1_item_reg.req_type;
        s2_eq_a_reg <= (s1_item_reg.presented_a == hash_status.token_a);
        s2_eq_b_reg <= (s1_item_reg.presented_b == hash_status.token_b);

        s3_result_reg.token_a      <= hash_status.token_a;
        s3_result_reg.token_b      <= hash_status.token_b;
        // Stamp beats never report a match
        s3_result_reg.tokens_match <= (s2_req_reg == stdc_pkg::REQ_VALIDATE)
                                      && s2_eq_a_reg && s2_eq_b_reg;
    end

    assign done   = s3_valid_reg;
    assign result = s3_result_reg;

endmodule

// File: rtl/stdc_checker.sv
// Port-level checker for the session token derive and check unit, with its bind.
module stdc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [stdc_pkg::WORD_W-1:0] cfg_data,
    input logic                        start,
    input logic                        busy,
    input stdc_pkg::item_t             item,
    input logic                        done,
    input stdc_pkg::result_t           result
);

    // Configuration is never taken while a derivation runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("cfg_ready high while busy");

    // Every taken request is followed by its result beat on done
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result beat missing after request");

    // A stamp request never reports a match
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.req_type == stdc_pkg::REQ_STAMP))
            |-> ##3 !result.tokens_match)
        else $error("match reported on stamp");

    // A nonzero code write starts a derivation
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_data != '0)) |=> busy)
        else $error("code write did not start derivation");

    // A zero code write is dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_data == '0)) |=> !busy)
        else $error("zero code write started derivation");

endmodule

bind session_token_derive_check_unit stdc_checker u_stdc_checker (.*);
